// ===== rtl/rgbe_rle_pkg.sv =====
package rgbe_rle_pkg;

  // line store geometry
  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned IDX_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LEFT_W    = WID_W + 2;

  // stream constants
  localparam logic [7:0] MARKER   = 8'd2;
  localparam logic [7:0] RUN_FLAG = 8'd128;

  // planes in stream order
  localparam logic [1:0] PLANE_RED = 2'd0;
  localparam logic [1:0] PLANE_GRN = 2'd1;
  localparam logic [1:0] PLANE_BLU = 2'd2;
  localparam logic [1:0] PLANE_EXP = 2'd3;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MARKER = 2'd1,
    ST_WIDTH      = 2'd2,
    ST_OVERRUN    = 2'd3
  } status_e;

  // byte parser phase
  typedef enum logic [6:0] {
    PH_MARK0   = 7'b0000001,
    PH_MARK1   = 7'b0000010,
    PH_WHI     = 7'b0000100,
    PH_WLO     = 7'b0001000,
    PH_COUNT   = 7'b0010000,
    PH_RUNVAL  = 7'b0100000,
    PH_LITERAL = 7'b1000000
  } phase_e;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input beat taken, parse it
    logic put;       // one decoded byte to the line store
    logic pix;       // merge the pixel read last cycle
    logic emit;      // load the pixel pair into the output register
    logic emit_err;  // load the error beat into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;        // accepted byte is a stream error
    logic need_put;   // accepted byte decodes into line store bytes
    logic exp_plane;  // current position is in the exponent plane
    logic rep_last;   // current put is the last of this byte
    logic emit_due;   // merged pair must go out now
    logic pix_last;   // merged pixel is the last of this byte
    logic out_free;   // output register can take a beat
  } stat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] exponent;
  } pixel_t;

  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] first_exponent;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] second_exponent;
    logic       second_present;
    logic       line_done;
    logic [1:0] status;
    logic       last_of_item;
  } beat_t;

endpackage

// ===== rtl/rgbe_rle_if.sv =====
// coded byte channel
interface rgbe_rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// decoded pixel pair channel
interface rgbe_rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_red;
  logic [7:0] first_green;
  logic [7:0] first_blue;
  logic [7:0] first_exponent;
  logic [7:0] second_red;
  logic [7:0] second_green;
  logic [7:0] second_blue;
  logic [7:0] second_exponent;
  logic       second_present;
  logic       line_done;
  logic [1:0] status;
  logic       last_of_item;

  modport source (
    output valid, input ready,
    output first_red, output first_green, output first_blue, output first_exponent,
    output second_red, output second_green, output second_blue, output second_exponent,
    output second_present, output line_done, output status, output last_of_item
  );
  modport sink (
    input valid, output ready,
    input first_red, input first_green, input first_blue, input first_exponent,
    input second_red, input second_green, input second_blue, input second_exponent,
    input second_present, input line_done, input status, input last_of_item
  );
endinterface

// ===== rtl/rgbe_rle_ctrl.sv =====
module rgbe_rle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  rgbe_rle_pkg::stat_t st_i,
  output rgbe_rle_pkg::cmd_t  cmd_o,
  output logic                in_ready_o
);
  import rgbe_rle_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PUT  = 6'b000010,
    S_PIX  = 6'b000100,
    S_EMIT = 6'b001000,
    S_ERR  = 6'b010000,
    S_HALT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (st_i.err) begin
            state_d = S_ERR;
          end else if (st_i.need_put) begin
            state_d = S_PUT;
          end
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        if (st_i.exp_plane) begin
          state_d = S_PIX;
        end else if (st_i.rep_last) begin
          state_d = S_IDLE;
        end
      end
      S_PIX: begin
        cmd_o.pix = 1'b1;
        if (st_i.emit_due) begin
          if (st_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = st_i.pix_last ? S_IDLE : S_PUT;
          end else begin
            state_d = S_EMIT;
          end
        end else begin
          state_d = S_PUT;
        end
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = st_i.pix_last ? S_IDLE : S_PUT;
        end
      end
      S_ERR: begin
        if (st_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_HALT;
        end
      end
      S_HALT: begin
        // bytes are taken and dropped until reset
        in_ready_o = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rgbe_rle_dp.sv =====
module rgbe_rle_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rgbe_rle_pkg::cmd_t  cmd_i,
  input  logic [7:0]          data_byte_i,
  input  logic                out_ready_i,
  output rgbe_rle_pkg::stat_t st_o,
  output logic                out_valid_o,
  output rgbe_rle_pkg::beat_t beat_o
);
  import rgbe_rle_pkg::*;

  // parser and position state
  phase_e            phase_q, phase_d;
  logic [7:0]        hi_q, hi_d;
  logic [WID_W-1:0]  width_q, width_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [1:0]        plane_q, plane_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]        pending_q, pending_d;
  logic [7:0]        rep_q, rep_d;
  logic [7:0]        val_q, val_d;
  status_e           err_code_q, err_code_d;
  logic              err_hit, put_hit;

  // line store and read side
  logic [7:0] red_mem [MAX_WIDTH];
  logic [7:0] grn_mem [MAX_WIDTH];
  logic [7:0] blu_mem [MAX_WIDTH];
  logic [7:0] red_rd_q, grn_rd_q, blu_rd_q;
  logic [7:0] pix_exp_q;
  logic       pix_last_q, pix_line_end_q;

  // pixel pair and output register
  pixel_t p0_q, p0_d, p1_q, p1_d;
  logic   half_q, half_d, pres_q, pres_d, ldone_q, ldone_d;
  pixel_t m_p0, m_p1, pix_in;
  logic   m_pres, m_ldone;
  logic   out_valid_q;
  beat_t  out_q;
  beat_t  pair_beat, err_beat;

  logic [15:0] full_w;
  logic        is_run;
  logic [7:0]  cnt;
  logic        idx_last;
  logic        out_free;

  assign full_w   = {hi_q, data_byte_i};
  assign is_run   = data_byte_i > RUN_FLAG;
  assign cnt      = is_run ? (data_byte_i - RUN_FLAG) : data_byte_i;
  assign idx_last = WID_W'(idx_q) == (width_q - WID_W'(1));
  assign out_free = !out_valid_q || out_ready_i;

  // byte parsing and position advance
  always_comb begin
    phase_d    = phase_q;
    hi_d       = hi_q;
    width_d    = width_q;
    left_d     = left_q;
    plane_d    = plane_q;
    idx_d      = idx_q;
    pending_d  = pending_q;
    rep_d      = rep_q;
    val_d      = val_q;
    err_code_d = err_code_q;
    err_hit    = 1'b0;
    put_hit    = 1'b0;
    if (cmd_i.accept) begin
      case (phase_q)
        PH_MARK0: begin
          if (data_byte_i != MARKER) begin
            err_hit    = 1'b1;
            err_code_d = ST_BAD_MARKER;
          end else begin
            phase_d = PH_MARK1;
          end
        end
        PH_MARK1: begin
          if (data_byte_i != MARKER) begin
            err_hit    = 1'b1;
            err_code_d = ST_BAD_MARKER;
          end else begin
            phase_d = PH_WHI;
          end
        end
        PH_WHI: begin
          hi_d    = data_byte_i;
          phase_d = PH_WLO;
        end
        PH_WLO: begin
          if (full_w > 16'(MAX_WIDTH)) begin
            err_hit    = 1'b1;
            err_code_d = ST_WIDTH;
          end else begin
            width_d = full_w[WID_W-1:0];
            left_d  = {full_w[WID_W-1:0], 2'b00};
            plane_d = PLANE_RED;
            idx_d   = '0;
            phase_d = (full_w == 16'd0) ? PH_MARK0 : PH_COUNT;
          end
        end
        PH_COUNT: begin
          if ((LEFT_W + 8)'(cnt) > (LEFT_W + 8)'(left_q)) begin
            err_hit    = 1'b1;
            err_code_d = ST_OVERRUN;
          end else if (cnt != 8'd0) begin
            pending_d = cnt;
            phase_d   = is_run ? PH_RUNVAL : PH_LITERAL;
          end
        end
        PH_RUNVAL: begin
          rep_d     = pending_q;
          val_d     = data_byte_i;
          pending_d = 8'd0;
          phase_d   = PH_COUNT;
          put_hit   = 1'b1;
        end
        PH_LITERAL: begin
          rep_d     = 8'd1;
          val_d     = data_byte_i;
          pending_d = pending_q - 8'd1;
          put_hit   = 1'b1;
          if (pending_q == 8'd1) begin
            phase_d = PH_COUNT;
          end
        end
        default: begin
          phase_d = PH_MARK0;
        end
      endcase
    end
    // one decoded byte moves the position on
    if (cmd_i.put) begin
      rep_d  = rep_q - 8'd1;
      left_d = left_q - LEFT_W'(1);
      if (left_q == LEFT_W'(1)) begin
        phase_d = PH_MARK0;
        plane_d = PLANE_RED;
        idx_d   = '0;
      end else if (idx_last) begin
        idx_d   = '0;
        plane_d = plane_q + 2'd1;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MARK0;
      hi_q       <= '0;
      width_q    <= '0;
      left_q     <= '0;
      plane_q    <= PLANE_RED;
      idx_q      <= '0;
      pending_q  <= '0;
      rep_q      <= '0;
      val_q      <= '0;
      err_code_q <= ST_OK;
    end else begin
      phase_q    <= phase_d;
      hi_q       <= hi_d;
      width_q    <= width_d;
      left_q     <= left_d;
      plane_q    <= plane_d;
      idx_q      <= idx_d;
      pending_q  <= pending_d;
      rep_q      <= rep_d;
      val_q      <= val_d;
      err_code_q <= err_code_d;
    end
  end

  // line store, one plane per array, read in the exponent plane
  always_ff @(posedge clk_i) begin
    if (cmd_i.put && plane_q == PLANE_RED) begin
      red_mem[idx_q] <= val_q;
    end
    if (cmd_i.put && plane_q == PLANE_EXP) begin
      red_rd_q <= red_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put && plane_q == PLANE_GRN) begin
      grn_mem[idx_q] <= val_q;
    end
    if (cmd_i.put && plane_q == PLANE_EXP) begin
      grn_rd_q <= grn_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put && plane_q == PLANE_BLU) begin
      blu_mem[idx_q] <= val_q;
    end
    if (cmd_i.put && plane_q == PLANE_EXP) begin
      blu_rd_q <= blu_mem[idx_q];
    end
  end

  // exponent byte and flags that travel with the read
  always_ff @(posedge clk_i) begin
    if (cmd_i.put && plane_q == PLANE_EXP) begin
      pix_exp_q      <= val_q;
      pix_last_q     <= rep_q == 8'd1;
      pix_line_end_q <= left_q == LEFT_W'(1);
    end
  end

  // pair assembly
  assign pix_in = '{red: red_rd_q, green: grn_rd_q, blue: blu_rd_q, exponent: pix_exp_q};

  always_comb begin
    m_p0    = p0_q;
    m_p1    = p1_q;
    m_pres  = pres_q;
    m_ldone = ldone_q;
    half_d  = half_q;
    if (cmd_i.pix) begin
      if (!half_q) begin
        m_p0   = pix_in;
        m_p1   = '0;
        m_pres = 1'b0;
        half_d = 1'b1;
      end else begin
        m_p1   = pix_in;
        m_pres = 1'b1;
        half_d = 1'b0;
      end
      m_ldone = ldone_q | pix_line_end_q;
    end
    p0_d    = m_p0;
    p1_d    = m_p1;
    pres_d  = m_pres;
    ldone_d = m_ldone;
    if (cmd_i.emit) begin
      p1_d    = '0;
      pres_d  = 1'b0;
      ldone_d = 1'b0;
      half_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= 1'b0;
      pres_q  <= 1'b0;
      ldone_q <= 1'b0;
    end else begin
      half_q  <= half_d;
      pres_q  <= pres_d;
      ldone_q <= ldone_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
  end

  // beats offered to the output register
  always_comb begin
    err_beat                  = '0;
    err_beat.status           = err_code_q;
    err_beat.last_of_item     = 1'b1;
    pair_beat.first_red       = m_p0.red;
    pair_beat.first_green     = m_p0.green;
    pair_beat.first_blue      = m_p0.blue;
    pair_beat.first_exponent  = m_p0.exponent;
    pair_beat.second_red      = m_p1.red;
    pair_beat.second_green    = m_p1.green;
    pair_beat.second_blue     = m_p1.blue;
    pair_beat.second_exponent = m_p1.exponent;
    pair_beat.second_present  = m_pres;
    pair_beat.line_done       = m_ldone;
    pair_beat.status          = ST_OK;
    pair_beat.last_of_item    = pix_last_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      out_q <= err_beat;
    end else if (cmd_i.emit) begin
      out_q <= pair_beat;
    end
  end

  // status to the controller
  assign st_o.err       = err_hit;
  assign st_o.need_put  = put_hit;
  assign st_o.exp_plane = plane_q == PLANE_EXP;
  assign st_o.rep_last  = rep_q == 8'd1;
  assign st_o.emit_due  = half_q || pix_last_q;
  assign st_o.pix_last  = pix_last_q;
  assign st_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign beat_o      = out_q;

endmodule

// ===== rtl/rgbe_scanline_rle_decoder.sv =====
// channel   modport  beat carries
// byte_i    sink     data_byte: one coded byte of the pixel stream
// pix_o     source   up to two decoded pixels, line_done, status, last_of_item
//
// marker, width and count bytes are taken in idle alone; a run value or literal byte
// adds a put per red, green or blue byte and a put plus a pix per exponent pixel
// reset clears the parser and the output register; the line store is not cleared
// a stalled output holds the decoder at the next finished pair
// after an error beat the block drops every byte until reset
module rgbe_scanline_rle_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  rgbe_rle_in_if.sink    byte_i,
  rgbe_rle_out_if.source pix_o
);
  import rgbe_rle_pkg::*;

  cmd_t  cmd;
  stat_t st;
  beat_t beat;
  logic  out_valid;
  logic  in_ready;

  rgbe_rle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  rgbe_rle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (byte_i.data_byte),
    .out_ready_i (pix_o.ready),
    .st_o        (st),
    .out_valid_o (out_valid),
    .beat_o      (beat)
  );

  // channel wiring
  assign byte_i.ready          = in_ready;
  assign pix_o.valid           = out_valid;
  assign pix_o.first_red       = beat.first_red;
  assign pix_o.first_green     = beat.first_green;
  assign pix_o.first_blue      = beat.first_blue;
  assign pix_o.first_exponent  = beat.first_exponent;
  assign pix_o.second_red      = beat.second_red;
  assign pix_o.second_green    = beat.second_green;
  assign pix_o.second_blue     = beat.second_blue;
  assign pix_o.second_exponent = beat.second_exponent;
  assign pix_o.second_present  = beat.second_present;
  assign pix_o.line_done       = beat.line_done;
  assign pix_o.status          = beat.status;
  assign pix_o.last_of_item    = beat.last_of_item;

  // an error beat carries no pixel and closes its byte
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.status != ST_OK)
      |-> (pix_o.last_of_item && !pix_o.second_present && !pix_o.line_done))
    else $error("error beat carries pixel flags");

  // nothing leaves after the error beat is taken
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.ready && pix_o.status != ST_OK) |=> !pix_o.valid)
    else $error("beat after error");

  // the line end always falls on the last decoded byte of a coded byte
  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.line_done) |-> pix_o.last_of_item)
    else $error("line end inside a run");

  // no new byte while the line store is busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.put || cmd.pix) |-> !byte_i.ready)
    else $error("byte taken while decoding");

endmodule
